/* sv/ria_pkg.sv */
// shared types, constants and the digit alphabet for the radix integer to ascii block
// no dependencies
`default_nettype none

package ria_pkg;

    localparam logic [7:0] RADIX_MIN = 8'd2;
    localparam logic [7:0] RADIX_MAX = 8'd36;
    localparam logic [7:0] CAP_MIN   = 8'd2;

    localparam int unsigned BASE_W  = 6;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 7'h57;
    localparam logic [BASE_W-1:0] DEC_DIGITS  = 6'd10;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  radix;
        logic [7:0]  capacity;
    } t_in_beat;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic [7:0]        position;
        logic              last;
        logic              empty_res;
    } t_out_beat;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + dx;
        end else begin
            return CHAR_ALPHA + dx;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/ria_if.sv */
// valid/ready channel interfaces for request and digit beats
// depends on ria_pkg
`default_nettype none

interface ria_in_if import ria_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ria_out_if import ria_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/radix_integer_to_ascii.sv */
// top level: request intake, digit sequencer and registered digit output
// depends on ria_pkg, ria_if, ria_divider
//
//  channel | dir | payload                                   | role
//  i_req   | in  | value, radix, capacity                    | one conversion request
//  o_dig   | out | digit_char, position, last, empty_res     | one digit, lsd first
//
// each digit comes from the divider, which works on VALUE_BITS bits (capped at 32)
// at one quotient bit per cycle; an invalid request gives its single empty beat
// in the cycle after acceptance.
// i_req.ready is high only between conversions and while the output register
// is free or being drained; a stalled o_dig holds its beat and pauses the sequencer.
// synchronous active-low reset clears the sequencer and the output valid.
`default_nettype none

module radix_integer_to_ascii import ria_pkg::*; #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ria_in_if.sink     i_req,
    ria_out_if.source  o_dig
);

    localparam int unsigned QW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUT
    } t_state;

    t_state    r_state,     n_state;
    logic [7:0] r_room,     n_room;
    logic [7:0] r_wpos,     n_wpos;
    logic [BASE_W-1:0] r_base, n_base;
    t_out_beat r_out,       n_out;
    logic      r_out_valid, n_out_valid;

    logic              in_fire;
    logic              out_free;
    logic              bad;
    logic              fin;
    logic              div_start;
    logic [QW-1:0]     div_dividend;
    logic [BASE_W-1:0] div_divisor;
    logic              div_done;
    logic [QW-1:0]     div_quot;
    logic [BASE_W-1:0] div_rem;

    ria_divider #(.QW(QW)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    always_comb begin
        out_free      = !r_out_valid || o_dig.ready;
        i_req.ready   = (r_state == S_IDLE) && out_free;
        in_fire       = i_req.valid && i_req.ready;
        bad           = (i_req.data.capacity < CAP_MIN) || (i_req.data.radix < RADIX_MIN)
                        || (i_req.data.radix > RADIX_MAX);
        fin           = (div_quot == '0) || (r_room == 8'd1);

        n_state       = r_state;
        n_room        = r_room;
        n_wpos        = r_wpos;
        n_base        = r_base;
        n_out         = r_out;
        n_out_valid   = o_dig.ready ? 1'b0 : r_out_valid;
        div_start     = 1'b0;
        div_dividend  = div_quot;
        div_divisor   = r_base;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (bad) begin
                        n_out.digit_char = CHAR_NONE;
                        n_out.position   = i_req.data.capacity;
                        n_out.last       = 1'b1;
                        n_out.empty_res  = 1'b1;
                        n_out_valid      = 1'b1;
                    end else begin
                        n_room       = i_req.data.capacity - 8'd1;
                        n_wpos       = i_req.data.capacity - 8'd1;
                        n_base       = i_req.data.radix[BASE_W-1:0];
                        div_start    = 1'b1;
                        div_dividend = i_req.data.value[QW-1:0];
                        div_divisor  = i_req.data.radix[BASE_W-1:0];
                        n_state      = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_out.digit_char = digit_to_char(div_rem);
                    n_out.position   = r_wpos;
                    n_out.last       = fin;
                    n_out.empty_res  = 1'b0;
                    n_out_valid      = 1'b1;
                    if (fin) begin
                        n_state = S_IDLE;
                    end else begin
                        n_wpos    = r_wpos - 8'd1;
                        n_room    = r_room - 8'd1;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_room      <= '0;
            r_wpos      <= '0;
            r_base      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_room      <= n_room;
            r_wpos      <= n_wpos;
            r_base      <= n_base;
        end
        r_out <= n_out;
    end

    assign o_dig.valid = r_out_valid;
    assign o_dig.data  = r_out;

endmodule

`default_nettype wire

/* sv/ria_divider.sv */
// iterative restoring divider, one quotient bit per cycle, small divisor
// depends on ria_pkg
`default_nettype none

module ria_divider import ria_pkg::*; #(
    parameter int unsigned QW = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [QW-1:0]     i_dividend,
    input  wire logic [BASE_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [QW-1:0]          o_quotient,
    output logic [BASE_W-1:0]      o_remainder
);

    localparam int unsigned CW = (QW > 1) ? $clog2(QW) : 1;

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [QW-1:0]     r_q;
    logic [BASE_W-1:0] r_rem;
    logic [BASE_W-1:0] r_div;

    logic [BASE_W:0]   sh;
    logic [BASE_W:0]   diff;
    logic              take;

    always_comb begin
        sh   = {r_rem, r_q[QW-1]};
        diff = sh - {1'b0, r_div};
        take = (sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(QW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[QW-2:0], take};
            r_rem <= take ? diff[BASE_W-1:0] : sh[BASE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

/* sv/ria_checker.sv */
// port-level checks for radix_integer_to_ascii, attached by bind
// depends on ria_pkg
`default_nettype none

module ria_checker import ria_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic [7:0]        i_req_radix,
    input wire logic [7:0]        i_req_size,
    input wire logic              o_dig_valid,
    input wire logic              o_dig_ready,
    input wire logic [CHAR_W-1:0] o_dig_char,
    input wire logic [7:0]        o_dig_pos,
    input wire logic              o_dig_last,
    input wire logic              o_dig_empty
);

    logic req_bad;
    assign req_bad = (i_req_size < CAP_MIN) || (i_req_radix < RADIX_MIN)
                     || (i_req_radix > RADIX_MAX);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig_valid && !o_dig_ready |=> o_dig_valid && $stable(o_dig_char)
            && $stable(o_dig_pos) && $stable(o_dig_last) && $stable(o_dig_empty))
        else $error("stalled digit beat changed");

    // invalid request answered by one empty beat next cycle
    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && req_bad |=> o_dig_valid && o_dig_empty && o_dig_last
            && (o_dig_pos == $past(i_req_size)))
        else $error("invalid request not answered by empty beat");

    // no new request while a conversion is still giving digits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig_valid && !o_dig_last |-> !i_req_ready)
        else $error("request taken mid conversion");

    // empty beat shape
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig_valid && o_dig_empty |-> o_dig_last && (o_dig_char == CHAR_NONE))
        else $error("malformed empty beat");

endmodule

bind radix_integer_to_ascii ria_checker u_ria_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_radix (i_req.data.radix),
    .i_req_size  (i_req.data.capacity),
    .o_dig_valid (o_dig.valid),
    .o_dig_ready (o_dig.ready),
    .o_dig_char  (o_dig.data.digit_char),
    .o_dig_pos   (o_dig.data.position),
    .o_dig_last  (o_dig.data.last),
    .o_dig_empty (o_dig.data.empty_res)
);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench for radix_integer_to_ascii: directed and random conversion requests,
// each digit beat checked against a digit predictor kept in this file
// depends on ria_pkg, ria_if and the radix_integer_to_ascii rtl

module testbench;
    import ria_pkg::*;

    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned GAP_PCT      = 27;
    localparam int unsigned RANDOM_ITEMS = 150;
    localparam int unsigned QUIET_ITEMS  = 40;
    localparam int unsigned MAX_DIGITS   = 64;

    logic i_clk;
    logic i_rst_n;

    ria_in_if  req_if ();
    ria_out_if dig_if ();

    radix_integer_to_ascii #(.VALUE_BITS(32)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_dig   (dig_if)
    );

    // predictor state
    logic [31:0] rem_value;
    logic [7:0]  slots_free;
    logic [7:0]  next_index;
    logic [5:0]  cur_base;
    logic        converting;

    t_out_beat pending_digits[$];
    int unsigned mismatch_count;
    logic gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(40_000_000);
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("mismatch: %s want %0h got %0h at %0t", what, want, got, $realtime);
    endtask

    function automatic void convert_to_digits(input t_in_beat beat);
        logic [5:0] d;
        logic       fin;
        t_out_beat  dig;
        int         n;
        n = 0;
        if (beat.capacity < CAP_MIN || beat.radix < RADIX_MIN || beat.radix > RADIX_MAX) begin
            rem_value  = beat.value;
            slots_free = '0;
            next_index = beat.capacity;
            cur_base   = beat.radix[5:0];
            converting = 1'b0;
            dig = '{digit_char: CHAR_NONE, position: beat.capacity,
                    last: 1'b1, empty_res: 1'b1};
            pending_digits.push_back(dig);
            return;
        end
        rem_value  = beat.value;
        cur_base   = beat.radix[5:0];
        slots_free = beat.capacity - 8'd1;
        next_index = beat.capacity - 8'd1;
        converting = 1'b1;
        while (converting && n < MAX_DIGITS) begin
            d          = 6'(rem_value % cur_base);
            rem_value  = rem_value / cur_base;
            slots_free = slots_free - 8'd1;
            fin        = (rem_value == 0) || (slots_free == 0);
            dig = '{digit_char: (d < DEC_DIGITS) ? CHAR_ZERO + {1'b0, d} : CHAR_ALPHA + {1'b0, d},
                    position: next_index, last: fin, empty_res: 1'b0};
            pending_digits.push_back(dig);
            n++;
            if (fin) begin
                converting = 1'b0;
            end else begin
                next_index = next_index - 8'd1;
            end
        end
        converting = 1'b0;
    endfunction

    // output side: random stalls
    always @(posedge i_clk) begin
        dig_if.ready <= !gaps_on || ($urandom_range(99) >= GAP_PCT);
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            if (pending_digits.size() == 0) begin
                report_mismatch("beat with nothing pending", '0, 32'(dig_if.data));
            end else begin
                want = pending_digits.pop_front();
                if (dig_if.data.digit_char !== want.digit_char)
                    report_mismatch("digit_char", want.digit_char, dig_if.data.digit_char);
                if (dig_if.data.position !== want.position)
                    report_mismatch("position", want.position, dig_if.data.position);
                if (dig_if.data.last !== want.last)
                    report_mismatch("last", want.last, dig_if.data.last);
                if (dig_if.data.empty_res !== want.empty_res)
                    report_mismatch("empty_res", want.empty_res, dig_if.data.empty_res);
            end
        end
    end

    task automatic send_request(input logic [31:0] value, input logic [7:0] radix,
                                input logic [7:0] capacity);
        t_in_beat beat;
        beat = '{value: value, radix: radix, capacity: capacity};
        while (gaps_on && $urandom_range(99) < GAP_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= beat;
        do @(posedge i_clk); while (!req_if.ready);
        convert_to_digits(beat);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_value_extremes();
        send_request(32'h0000_0000, 8'd10, 8'd255);
        send_request(32'hffff_ffff, RADIX_MIN, 8'd255);
        send_request(32'hffff_ffff, RADIX_MAX, 8'd255);
        send_request(32'hffff_ffff, 8'd10, 8'd11);
        send_request(32'h8000_0000, 8'd16, 8'd9);
        send_request(32'd35, RADIX_MAX, 8'd4);
        send_request(32'd12345678, 8'd10, 8'd200);
        wait_drained();
    endtask

    task automatic test_empty_results();
        send_request(32'd1234, 8'd10, 8'd0);
        send_request(32'd1234, 8'd10, CAP_MIN - 8'd1);
        send_request(32'd1234, 8'd0, 8'd50);
        send_request(32'd1234, RADIX_MIN - 8'd1, 8'd50);
        send_request(32'd1234, RADIX_MAX + 8'd1, 8'd50);
        send_request(32'hffff_ffff, 8'd255, 8'd255);
        send_request(32'h0000_0000, 8'd128, 8'd1);
        wait_drained();
    endtask

    task automatic test_truncation();
        send_request(32'd12345, 8'd10, CAP_MIN);
        send_request(32'd12345, 8'd10, 8'd4);
        send_request(32'h0000_0000, RADIX_MIN, CAP_MIN);
        send_request(32'hffff_ffff, RADIX_MIN, 8'd33);
        send_request(32'hffff_ffff, RADIX_MIN, 8'd32);
        send_request(32'd255, 8'd16, 8'd3);
        send_request(32'd256, 8'd16, 8'd3);
        wait_drained();
    endtask

    task automatic send_random_request();
        logic [31:0] value;
        logic [7:0]  radix;
        logic [7:0]  capacity;
        int unsigned kind;
        kind  = $urandom_range(99);
        value = $urandom;
        if ($urandom_range(3) == 0) value = value >> $urandom_range(31);
        if ($urandom_range(19) == 0) value = '0;
        radix    = 8'($urandom_range(RADIX_MAX, RADIX_MIN));
        capacity = ($urandom_range(3) == 0) ? 8'($urandom_range(12, CAP_MIN))
                                            : 8'($urandom_range(255, 13));
        if (kind >= 80 && kind < 90) begin
            radix = ($urandom_range(1) == 0) ? 8'($urandom_range(RADIX_MIN - 1, 0))
                                             : 8'($urandom_range(255, RADIX_MAX + 1));
            capacity = 8'($urandom);
        end else if (kind >= 90) begin
            capacity = 8'($urandom_range(CAP_MIN - 1, 0));
            if ($urandom_range(1) == 0) radix = 8'($urandom);
        end
        send_request(value, radix, capacity);
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gaps_on = (i >= QUIET_ITEMS);
            if (i == RANDOM_ITEMS / 2) wait_drained();
            send_random_request();
        end
    endtask

    initial begin
        mismatch_count = 0;
        gaps_on        = 1'b1;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        converting     = 1'b0;
        rem_value      = '0;
        slots_free     = '0;
        next_index     = '0;
        cur_base       = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_value_extremes();
        test_empty_results();
        test_truncation();
        test_random();

        wait_drained();
        if (pending_digits.size() != 0)
            report_mismatch("digits never produced", pending_digits.size(), '0);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
